@@ rtl/modexp_pkg.sv @@
// modexp_pkg: word widths, register indexes and the command/response types of the
// shared modular multiplier; used by every rtl file of the modular exponentiation core
package modexp_pkg;

   localparam int WORD_BITS = 32;
   localparam int NMOD_BITS = WORD_BITS + 1;
   localparam int TMP_BITS  = WORD_BITS + 3;
   localparam int CNT_BITS  = $clog2(WORD_BITS);
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_EXPONENT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MODULUS  = 1'd1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [NMOD_BITS-1:0] nmod_type;

   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
      nmod_type n;
   } mul_cmd_type;

   typedef struct packed {
      logic     done;
      word_type product;
   } mul_rsp_type;

endpackage

@@ rtl/modexp_if.sv @@
// valid/ready channel interfaces for the message and ciphertext items
// depends on modexp_pkg
interface modexp_req_if import modexp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type message;

   modport source (output valid, output message, input ready);
   modport sink (input valid, input message, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type ciphertext;

   modport source (output valid, output ciphertext, input ready);
   modport sink (input valid, input ciphertext, output ready);
endinterface

@@ rtl/modexp_mulmod.sv @@
// modexp_mulmod: bit-serial add-and-double modular multiplier, one multiplier bit per cycle
// depends on modexp_pkg; a zero modulus arrives here as 2^WORD_BITS
module modexp_mulmod import modexp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   word_type            acc_ff, acc_in;
   word_type            a_ff, a_in;
   word_type            b_ff, b_in;
   nmod_type            n_ff, n_in;

   logic [TMP_BITS-1:0] sum;
   logic [TMP_BITS-1:0] sub_one;
   logic [TMP_BITS-1:0] sub_two;
   word_type            step;

   // 2*acc + a*bit < 3n, so at most two subtractions of n
   always_comb begin
      sum     = (TMP_BITS'(acc_ff) << 1) + (b_ff[WORD_BITS-1] ? TMP_BITS'(a_ff) : '0);
      sub_one = sum - TMP_BITS'(n_ff);
      sub_two = sum - (TMP_BITS'(n_ff) << 1);
      if (!sub_two[TMP_BITS-1]) begin
         step = sub_two[WORD_BITS-1:0];
      end else if (!sub_one[TMP_BITS-1]) begin
         step = sub_one[WORD_BITS-1:0];
      end else begin
         step = sum[WORD_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = cmd.a;
         b_in    = cmd.b;
         n_in    = cmd.n;
      end else if (busy_ff) begin
         acc_in = step;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

@@ rtl/modular_exponentiation_core.sv @@
// modular_exponentiation_core: ciphertext = message^exponent mod modulus, square-and-multiply
// from the top exponent bit over one shared bit-serial multiplier (modexp_mulmod)
// path to rsp valid: a zero exponent goes straight to the result; else one reduction of the message,
// then a square per exponent bit and a multiply per set bit, the multiplier taking one bit per cycle
// throughput: one item at a time, req ready only between items
// reset: synchronous, active high; exponent and modulus return to 1, no item in flight
module modular_exponentiation_core import modexp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   modexp_req_if.sink              req_chan,
   modexp_rsp_if.source            rsp_chan,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  word_type                csr_wdata
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_REDUCE   = 3'd1;
   localparam logic [2:0] ST_SQ_ISSUE = 3'd2;
   localparam logic [2:0] ST_SQ_WAIT  = 3'd3;
   localparam logic [2:0] ST_MU_ISSUE = 3'd4;
   localparam logic [2:0] ST_MU_WAIT  = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]          state_ff, state_in;
   word_type            exp_ff, exp_in;
   word_type            mod_ff, mod_in;
   word_type            base_ff, base_in;
   word_type            acc_ff, acc_in;
   word_type            ebits_ff, ebits_in;
   logic [CNT_BITS-1:0] bit_ff, bit_in;
   word_type            out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   nmod_type    n_eff;
   word_type    one_mod;
   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;
   logic        req_fire;
   logic        last_bit;

   modexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   // a zero modulus means plain wrap, i.e. modulo 2^WORD_BITS
   assign n_eff    = (mod_ff == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, mod_ff};
   assign one_mod  = (mod_ff == word_type'(1)) ? '0 : word_type'(1);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign last_bit = (bit_ff == CNT_BITS'(WORD_BITS - 1));

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.ciphertext = out_ff;

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      ebits_in     = ebits_ff;
      bit_in       = bit_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      mul_cmd      = '{start: 1'b0, a: acc_ff, b: acc_ff, n: n_eff};

      if (csr_we) begin
         case (csr_index)
            REG_EXPONENT: exp_in = csr_wdata;
            REG_MODULUS:  mod_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_chan.valid && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (exp_ff == '0) begin
                  acc_in   = word_type'(1);
                  state_in = ST_DONE;
               end else begin
                  // message mod n by Horner over its bits: (1 mod n) * message
                  mul_cmd  = '{start: 1'b1, a: one_mod, b: req_chan.message, n: n_eff};
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.product;
               acc_in   = one_mod;
               ebits_in = exp_ff;
               bit_in   = '0;
               state_in = ST_SQ_ISSUE;
            end
         end
         ST_SQ_ISSUE: begin
            mul_cmd  = '{start: 1'b1, a: acc_ff, b: acc_ff, n: n_eff};
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               if (ebits_ff[WORD_BITS-1]) begin
                  state_in = ST_MU_ISSUE;
               end else begin
                  ebits_in = ebits_ff << 1;
                  bit_in   = bit_ff + 1'b1;
                  state_in = last_bit ? ST_DONE : ST_SQ_ISSUE;
               end
            end
         end
         ST_MU_ISSUE: begin
            mul_cmd  = '{start: 1'b1, a: acc_ff, b: base_ff, n: n_eff};
            state_in = ST_MU_WAIT;
         end
         ST_MU_WAIT: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.product;
               ebits_in = ebits_ff << 1;
               bit_in   = bit_ff + 1'b1;
               state_in = last_bit ? ST_DONE : ST_SQ_ISSUE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = acc_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= word_type'(1);
         mod_ff       <= word_type'(1);
         bit_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         mod_ff       <= mod_in;
         bit_ff       <= bit_in;
         out_valid_ff <= out_valid_in;
      end
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      ebits_ff <= ebits_in;
      out_ff   <= out_in;
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for modular_exponentiation_core, ciphertext = message^exponent mod n
// depends on modexp_pkg, the modexp_req_if / modexp_rsp_if channels and the core rtl
module tb;
   import modexp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 5000;
   localparam int TAIL_CYCLES    = 3000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 25;
   localparam word_type ALL_ONES = {WORD_BITS{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic send_valid = 1'b0;
   word_type send_message = '0;
   logic take_ready = 1'b0;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = REG_EXPONENT;
   word_type csr_wdata = '0;

   word_type key_exponent = word_type'(1);
   word_type key_modulus = word_type'(1);
   word_type message_q[$];
   word_type cipher_due_q[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int failures = 0;

   modexp_req_if req_bus ();
   modexp_rsp_if rsp_bus ();

   assign req_bus.valid = send_valid;
   assign req_bus.message = send_message;
   assign rsp_bus.ready = take_ready;

   modular_exponentiation_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // product reduced mod n, or wrapped to the word when n is zero
   function automatic longint unsigned mul_reduce(longint unsigned a, longint unsigned b,
                                                   longint unsigned n);
      if (n == 0) return (a * b) & ((64'd1 << WORD_BITS) - 1);
      return (a * b) % n;
   endfunction

   function automatic word_type rsa_power(word_type msg, word_type ex, word_type md);
      longint unsigned n;
      longint unsigned base;
      longint unsigned acc;
      int i;
      n = 64'(md);
      if (ex == '0) return word_type'(1);
      if (n == 0) begin
         base = 64'(msg);
         acc = 1;
      end else begin
         base = 64'(msg) % n;
         acc = 1 % n;
      end
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         acc = mul_reduce(acc, acc, n);
         if (ex[i]) acc = mul_reduce(acc, base, n);
      end
      return word_type'(acc);
   endfunction

   function automatic word_type pick_exponent();
      case ($urandom_range(6))
         0: return '0;
         1: return word_type'(1);
         2: return word_type'(65537);
         3: return ALL_ONES;
         4: return word_type'(1) << $urandom_range(WORD_BITS - 1);
         5: return word_type'($urandom_range(17, 2));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_modulus();
      word_type md;
      case ($urandom_range(5))
         0: md = word_type'(1);
         1: md = word_type'(2);
         2: md = ALL_ONES;
         3: md = word_type'($urandom) | 32'h8000_0000;
         4: md = word_type'($urandom_range(65535, 3));
         default: md = word_type'($urandom);
      endcase
      if (md == '0) md = word_type'(1);
      return md;
   endfunction

   function automatic word_type pick_message(word_type md);
      case ($urandom_range(5))
         0: return word_type'($urandom) % md;
         1: return md - 1;
         2: return word_type'($urandom_range(1));
         3: return ALL_ONES;
         4: return word_type'($urandom_range(255));
         default: return word_type'($urandom);
      endcase
   endfunction

   // message driver
   always @(posedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else begin
         if (send_valid && req_bus.ready) begin
            cipher_due_q.push_back(rsa_power(send_message, key_exponent, key_modulus));
         end
         if (!send_valid || req_bus.ready) begin
            if (message_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               send_valid <= 1'b1;
               send_message <= message_q.pop_front();
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   // ciphertext monitor
   always @(posedge clock) begin
      word_type due;
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (take_ready && rsp_bus.valid) begin
            if (cipher_due_q.size() == 0) begin
               $error("ciphertext: expected none, actual %h", rsp_bus.ciphertext);
               failures++;
            end else begin
               due = cipher_due_q.pop_front();
               if (rsp_bus.ciphertext !== due) begin
                  $error("ciphertext: expected %h, actual %h", due, rsp_bus.ciphertext);
                  failures++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take_ready <= 1'b0;
         end else begin
            take_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((send_valid && req_bus.ready) || (take_ready && rsp_bus.valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, word_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_key(word_type ex, word_type md);
      write_reg(REG_EXPONENT, ex);
      write_reg(REG_MODULUS, md);
      key_exponent = ex;
      key_modulus = md;
      @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
         default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
   endtask

   // wait until every item has gone through and the core is idle
   task automatic settle();
      @(negedge clock);
      while (message_q.size() != 0 || send_valid || cipher_due_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int phase;
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key left at reset: modulus one gives zero
      message_q.push_back('0);
      message_q.push_back(ALL_ONES);
      settle();

      // zero exponent gives one, modulus one included
      set_idling(1);
      set_key('0, word_type'(1));
      message_q.push_back(word_type'(5));
      settle();
      set_idling(2);
      set_key('0, ALL_ONES);
      message_q.push_back('0);
      message_q.push_back(ALL_ONES);
      settle();

      // small textbook key, messages below, at and above the modulus
      set_idling(3);
      set_key(word_type'(65537), word_type'(3233));
      message_q.push_back(word_type'(65));
      message_q.push_back('0);
      message_q.push_back(word_type'(1));
      message_q.push_back(word_type'(3232));
      message_q.push_back(word_type'(3233));
      message_q.push_back(ALL_ONES);
      settle();

      // widest exponent and modulus, then exponent two under a modulus near the top
      set_idling(0);
      set_key(ALL_ONES, ALL_ONES);
      message_q.push_back('0);
      message_q.push_back(word_type'(1));
      message_q.push_back(word_type'(2));
      message_q.push_back(ALL_ONES - 1);
      message_q.push_back(ALL_ONES);
      message_q.push_back(word_type'(32'h1234_5678));
      settle();
      set_key(word_type'(2), word_type'(32'hFFFF_FFFB));
      message_q.push_back(word_type'(32'hFFFF_FFFA));
      message_q.push_back(word_type'(32'h8000_0000));
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(phase);
         set_key(pick_exponent(), pick_modulus());
         if (phase == 0) hold_requests++;
         for (k = 0; k < PHASE_ITEMS; k++) message_q.push_back(pick_message(key_modulus));
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/modexp_pkg.sv
rtl/modexp_if.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation_core.sv
verif/tb.sv
